// ===== src/sicore_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sicore_pkg
// Shared constants, opcode codes and types of the scalar integer core.
// ----------------------------------------------------------------------------
package sicore_pkg;

   // data memory geometry (byte count must be a power of two, at least 16)
   localparam int DMEM_BYTES = 4096;
   localparam int DMEM_AW    = $clog2(DMEM_BYTES);
   localparam int BANK_ROWS  = DMEM_BYTES / 4;
   localparam int ROW_AW     = DMEM_AW - 2;

   // program counter width
   localparam int PC_W = 12;

   // register file geometry
   localparam int RF_DEPTH = 32;
   localparam int RF_AW    = 5;

   // link register
   localparam logic [RF_AW-1:0] REG_LINK = 5'd31;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_LWU     = 6'h27;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // special function codes
   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_SRA   = 6'h03;
   localparam logic [5:0] FN_SLLV  = 6'h04;
   localparam logic [5:0] FN_SRLV  = 6'h06;
   localparam logic [5:0] FN_SRAV  = 6'h07;
   localparam logic [5:0] FN_JR    = 6'h08;
   localparam logic [5:0] FN_JALR  = 6'h09;
   localparam logic [5:0] FN_BREAK = 6'h0D;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_SUBU  = 6'h23;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_XOR   = 6'h26;
   localparam logic [5:0] FN_NOR   = 6'h27;
   localparam logic [5:0] FN_SLT   = 6'h2A;
   localparam logic [5:0] FN_SLTU  = 6'h2B;

   // regimm rt codes
   localparam logic [4:0] RI_BLTZ   = 5'h00;
   localparam logic [4:0] RI_BGEZ   = 5'h01;
   localparam logic [4:0] RI_BLTZAL = 5'h10;
   localparam logic [4:0] RI_BGEZAL = 5'h11;

   // store size codes
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   // kind of load whose data comes back from memory
   typedef enum logic [2:0] {
      LD_NONE,
      LD_BYTE,
      LD_BYTE_U,
      LD_HALF,
      LD_HALF_U,
      LD_WORD
   } load_kind_type;

   // decoded and executed view of one instruction
   typedef struct packed {
      logic               reg_we;
      logic [RF_AW-1:0]   reg_index;
      logic [31:0]        reg_value;
      load_kind_type      load_kind;
      logic               mem_we;
      logic [1:0]         mem_size;
      logic [DMEM_AW-1:0] ea;
      logic               brk;
      logic               unsup;
      logic               taken;
      logic [PC_W-1:0]    target;
   } exec_res_type;

endpackage
`default_nettype wire

// ===== src/scalar_integer_core_step_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each instruction is registered in execute, then its result in the result stage.
// Throughput: one instruction per cycle while the result side does not stall;
// the execute stage and its register file and data memory ports run once a cycle.
// Reset: pc triple goes to 0/4/8, register file reads zero at once, and the
// data memory is cleared one row of four bytes a cycle, during which req_stall
// stays high.
// ----------------------------------------------------------------------------
// scalar_integer_core_step_top
// Scalar integer core with one branch delay slot: two-stage pipeline with an
// execute stage and a writeback/result stage, 32x32 register file and a
// four-bank byte-wide big-endian data memory.
// ----------------------------------------------------------------------------
module scalar_integer_core_step_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instr,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_next_fetch_pc,
   output logic             rsp_reg_we,
   output logic [4:0]       rsp_reg_index,
   output logic [31:0]      rsp_reg_value,
   output logic             rsp_mem_we,
   output logic [11:0]      rsp_mem_addr,
   output logic [1:0]       rsp_mem_size,
   output logic [31:0]      rsp_mem_data,
   output logic             rsp_break_hit,
   output logic             rsp_unsupported
);

   localparam int PC_W    = sicore_pkg::PC_W;
   localparam int DMEM_AW = sicore_pkg::DMEM_AW;
   localparam int ROW_AW  = sicore_pkg::ROW_AW;
   localparam int RF_AW   = sicore_pkg::RF_AW;

   // handshake and pipeline control
   logic accept;
   logic s1_adv;
   logic s2_ready;

   // memory clear sequencer
   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic [ROW_AW-1:0] clr_row_ff;
   logic [ROW_AW-1:0] clr_row_in;

   // pc triple
   logic [PC_W-1:0] cur_pc_ff;
   logic [PC_W-1:0] cur_pc_in;
   logic [PC_W-1:0] next_pc_ff;
   logic [PC_W-1:0] next_pc_in;
   logic [PC_W-1:0] after_pc_ff;
   logic [PC_W-1:0] after_pc_in;
   logic [PC_W-1:0] new_next_pc;

   // register file
   logic [31:0]         rf_mem [sicore_pkg::RF_DEPTH];
   logic [31:0]         rf_valid_ff;
   logic [31:0]         rf_valid_in;
   logic                rf_wr_en;
   logic [RF_AW-1:0]    rf_wr_idx;
   logic [31:0]         rf_wr_val;
   logic [RF_AW-1:0]    req_rs;
   logic [RF_AW-1:0]    req_rt;

   // execute stage
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [31:0] s1_instr_ff;
   logic [31:0] s1_a_ff;
   logic [31:0] s1_b_ff;
   logic [31:0] op_a;
   logic [31:0] op_b;
   sicore_pkg::exec_res_type ex_res;

   // data memory banks
   logic [3:0][ROW_AW-1:0] bank_row;
   logic [3:0]             bank_we;
   logic [3:0][7:0]        bank_wd;
   logic [3:0][7:0]        bank_rd;
   logic [1:0]             ea_lo;
   logic [ROW_AW-1:0]      ea_row;
   logic [31:0]            st_aligned;
   logic [1:0]             lane_off;
   logic                   lane_used;
   logic [1:0]             lane_idx;

   // result stage
   logic                      s2_valid_ff;
   logic                      s2_valid_in;
   logic [PC_W-1:0]           s2_fetch_pc_ff;
   logic                      s2_reg_we_ff;
   logic [RF_AW-1:0]          s2_reg_index_ff;
   logic [31:0]               s2_value_ff;
   sicore_pkg::load_kind_type s2_load_kind_ff;
   logic [1:0]                s2_lo_ff;
   logic                      s2_mem_we_ff;
   logic [DMEM_AW-1:0]        s2_mem_addr_ff;
   logic [1:0]                s2_mem_size_ff;
   logic [31:0]               s2_mem_data_ff;
   logic                      s2_brk_ff;
   logic                      s2_unsup_ff;
   logic [31:0]               ld_word;
   logic [31:0]               s2_result;

   // handshake
   assign s2_ready  = !s2_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && s2_ready;
   assign req_stall = clr_busy_ff || (s1_valid_ff && !s2_ready);
   assign accept    = req_valid && !req_stall;

   // clear sequencer: one row of all four banks per cycle after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (clr_busy_ff) begin
         clr_row_in = clr_row_ff + ROW_AW'(1);
         if (&clr_row_ff) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
      end
   end

   // pc triple advances as each instruction leaves execute
   assign new_next_pc = ex_res.taken ? ex_res.target : after_pc_ff;

   always_comb begin
      cur_pc_in   = cur_pc_ff;
      next_pc_in  = next_pc_ff;
      after_pc_in = after_pc_ff;
      if (s1_adv) begin
         cur_pc_in   = {next_pc_ff[PC_W-1:2], 2'b00};
         next_pc_in  = new_next_pc;
         after_pc_in = new_next_pc + PC_W'(4);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_pc_ff   <= PC_W'(0);
         next_pc_ff  <= PC_W'(4);
         after_pc_ff <= PC_W'(8);
      end else begin
         cur_pc_ff   <= cur_pc_in;
         next_pc_ff  <= next_pc_in;
         after_pc_ff <= after_pc_in;
      end
   end

   // register file write from the result stage, idempotent while it waits
   assign rf_wr_en  = s2_valid_ff && s2_reg_we_ff;
   assign rf_wr_idx = s2_reg_index_ff;
   assign rf_wr_val = s2_result;

   always_comb begin
      rf_valid_in = rf_valid_ff;
      if (rf_wr_en) begin
         rf_valid_in[rf_wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else begin
         rf_valid_ff <= rf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_wr_en) begin
         rf_mem[rf_wr_idx] <= rf_wr_val;
      end
   end

   // operand read at transfer, write-through from the same-cycle writeback
   assign req_rs = req_instr[25:21];
   assign req_rt = req_instr[20:16];

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instr;
         if (rf_wr_en && (rf_wr_idx == req_rs)) begin
            s1_a_ff <= rf_wr_val;
         end else if (rf_valid_ff[req_rs]) begin
            s1_a_ff <= rf_mem[req_rs];
         end else begin
            s1_a_ff <= 32'h0000_0000;
         end
         if (rf_wr_en && (rf_wr_idx == req_rt)) begin
            s1_b_ff <= rf_wr_val;
         end else if (rf_valid_ff[req_rt]) begin
            s1_b_ff <= rf_mem[req_rt];
         end else begin
            s1_b_ff <= 32'h0000_0000;
         end
      end
   end

   // execute stage occupancy
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // forward the older instruction still in the result stage
   assign op_a = (rf_wr_en && (rf_wr_idx == s1_instr_ff[25:21])) ? s2_result : s1_a_ff;
   assign op_b = (rf_wr_en && (rf_wr_idx == s1_instr_ff[20:16])) ? s2_result : s1_b_ff;

   sicore_exec u_exec (
      .instr         (s1_instr_ff),
      .op_a          (op_a),
      .op_b          (op_b),
      .next_pc       (next_pc_ff),
      .after_next_pc (after_pc_ff),
      .res           (ex_res)
   );

   // bank steering: byte k of an access lives in bank (ea + k) mod 4
   assign ea_lo  = ex_res.ea[1:0];
   assign ea_row = ex_res.ea[DMEM_AW-1:2];

   always_comb begin
      unique case (ex_res.mem_size)
         sicore_pkg::SIZE_WORD: st_aligned = op_b;
         sicore_pkg::SIZE_HALF: st_aligned = {op_b[15:0], 16'h0000};
         default:               st_aligned = {op_b[7:0], 24'h000000};
      endcase
   end

   always_comb begin
      lane_off  = 2'b00;
      lane_used = 1'b0;
      for (int k = 0; k < 4; k++) begin
         lane_off  = 2'(2'(k) - ea_lo);
         lane_used = (ex_res.mem_size == sicore_pkg::SIZE_WORD) ||
                     ((ex_res.mem_size == sicore_pkg::SIZE_HALF) && !lane_off[1]) ||
                     (lane_off == 2'b00);
         if (clr_busy_ff) begin
            bank_row[k] = clr_row_ff;
            bank_we[k]  = 1'b1;
            bank_wd[k]  = 8'h00;
         end else begin
            bank_row[k] = ea_row + ROW_AW'(2'(k) < ea_lo);
            bank_we[k]  = s1_adv && ex_res.mem_we && lane_used;
            bank_wd[k]  = st_aligned[8*(3-lane_off) +: 8];
         end
      end
   end

   // four byte banks, read data registered as the instruction moves on
   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [7:0] bank_mem [sicore_pkg::BANK_ROWS];
      logic [7:0] rd_ff;

      always_ff @(posedge clock) begin
         if (bank_we[k]) begin
            bank_mem[bank_row[k]] <= bank_wd[k];
         end
         if (s1_adv) begin
            rd_ff <= bank_mem[bank_row[k]];
         end
      end

      assign bank_rd[k] = rd_ff;
   end

   // result stage occupancy
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   // result stage payload
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_fetch_pc_ff  <= {next_pc_ff[PC_W-1:2], 2'b00};
         s2_reg_we_ff    <= ex_res.reg_we;
         s2_reg_index_ff <= ex_res.reg_index;
         s2_value_ff     <= ex_res.reg_value;
         s2_load_kind_ff <= ex_res.load_kind;
         s2_lo_ff        <= ea_lo;
         s2_mem_we_ff    <= ex_res.mem_we;
         s2_mem_addr_ff  <= ex_res.mem_we ? ex_res.ea : '0;
         s2_mem_size_ff  <= ex_res.mem_we ? ex_res.mem_size : sicore_pkg::SIZE_BYTE;
         s2_mem_data_ff  <= ex_res.mem_we ? op_b : 32'h0000_0000;
         s2_brk_ff       <= ex_res.brk;
         s2_unsup_ff     <= ex_res.unsup;
      end
   end

   // big-endian load assembly, first byte most significant
   always_comb begin
      lane_idx = 2'b00;
      ld_word  = 32'h0000_0000;
      for (int j = 0; j < 4; j++) begin
         lane_idx = 2'(s2_lo_ff + 2'(j));
         ld_word[8*(3-j) +: 8] = bank_rd[lane_idx];
      end
   end

   always_comb begin
      case (s2_load_kind_ff)
         sicore_pkg::LD_BYTE:   s2_result = {{24{ld_word[31]}}, ld_word[31:24]};
         sicore_pkg::LD_BYTE_U: s2_result = {24'h000000, ld_word[31:24]};
         sicore_pkg::LD_HALF:   s2_result = {{16{ld_word[31]}}, ld_word[31:16]};
         sicore_pkg::LD_HALF_U: s2_result = {16'h0000, ld_word[31:16]};
         sicore_pkg::LD_WORD:   s2_result = ld_word;
         default:               s2_result = s2_value_ff;
      endcase
   end

   // result ports
   assign rsp_valid         = s2_valid_ff;
   assign rsp_next_fetch_pc = s2_fetch_pc_ff;
   assign rsp_reg_we        = s2_reg_we_ff;
   assign rsp_reg_index     = s2_reg_index_ff;
   assign rsp_reg_value     = s2_result;
   assign rsp_mem_we        = s2_mem_we_ff;
   assign rsp_mem_addr      = 12'(s2_mem_addr_ff);
   assign rsp_mem_size      = s2_mem_size_ff;
   assign rsp_mem_data      = s2_mem_data_ff;
   assign rsp_break_hit     = s2_brk_ff;
   assign rsp_unsupported   = s2_unsup_ff;

`ifndef SYNTHESIS
   // pc triple keeps its fixed spacing
   a_pc_spacing: assert property (@(posedge clock) disable iff (reset)
      after_pc_ff == next_pc_ff + PC_W'(4))
      else $error("after_next_pc is not next_pc plus four");

   // no instruction in flight while the data memory is being cleared
   a_idle_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("instruction in flight during memory clear");

   // register zero is never reported as written
   a_no_reg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reg_we) |-> (rsp_reg_index != '0))
      else $error("write to register zero reported");

   // a store never also writes a register
   a_store_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_mem_we && rsp_reg_we))
      else $error("store and register write in one result");

   // a waiting instruction in execute keeps its word until it moves on
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_instr_ff)))
      else $error("execute stage lost its instruction while blocked");
`endif

endmodule
`default_nettype wire

// ===== src/sicore_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sicore_exec
// Decode and execute of one instruction word: alu, shifts, compares,
// branch resolution, effective address and register write selection.
// ----------------------------------------------------------------------------
module sicore_exec (
   input  wire logic [31:0]                  instr,
   input  wire logic [31:0]                  op_a,
   input  wire logic [31:0]                  op_b,
   input  wire logic [sicore_pkg::PC_W-1:0]  next_pc,
   input  wire logic [sicore_pkg::PC_W-1:0]  after_next_pc,
   output sicore_pkg::exec_res_type          res
);

   logic [5:0]  prim;
   logic [5:0]  funct;
   logic [4:0]  rs_idx;
   logic [4:0]  rt_idx;
   logic [4:0]  rd_idx;
   logic [4:0]  sa;
   logic [31:0] imm_z;
   logic [31:0] imm_s;
   logic [31:0] link_val;
   logic [31:0] sum_ab;
   logic [31:0] diff_ab;
   logic [31:0] sum_ai;
   logic [sicore_pkg::PC_W-1:0] rel_target;
   logic [sicore_pkg::PC_W-1:0] jmp_target;
   logic        a_neg;
   logic        a_zero;

   logic                    do_wr;
   logic [4:0]              wr_idx;
   logic [31:0]             wr_val;
   sicore_pkg::load_kind_type ld_kind;
   logic                    st_en;
   logic [1:0]              st_size;
   logic                    brk;
   logic                    unsup;
   logic                    taken;
   logic [sicore_pkg::PC_W-1:0] target;
   logic                    wr_ok;

   // field extraction and shared datapath
   assign prim       = instr[31:26];
   assign rs_idx     = instr[25:21];
   assign rt_idx     = instr[20:16];
   assign rd_idx     = instr[15:11];
   assign sa         = instr[10:6];
   assign funct      = instr[5:0];
   assign imm_z      = {16'h0000, instr[15:0]};
   assign imm_s      = {{16{instr[15]}}, instr[15:0]};
   assign link_val   = {20'h00000, after_next_pc[sicore_pkg::PC_W-1:2], 2'b00};
   assign sum_ab     = op_a + op_b;
   assign diff_ab    = op_a - op_b;
   assign sum_ai     = op_a + imm_s;
   assign rel_target = next_pc + {imm_s[sicore_pkg::PC_W-3:0], 2'b00};
   assign jmp_target = {instr[sicore_pkg::PC_W-3:0], 2'b00};
   assign a_neg      = op_a[31];
   assign a_zero     = (op_a == 32'h0000_0000);

   // opcode decoder
   always_comb begin
      do_wr   = 1'b0;
      wr_idx  = rd_idx;
      wr_val  = 32'h0000_0000;
      ld_kind = sicore_pkg::LD_NONE;
      st_en   = 1'b0;
      st_size = sicore_pkg::SIZE_BYTE;
      brk     = 1'b0;
      unsup   = 1'b0;
      taken   = 1'b0;
      target  = '0;
      unique case (prim)
         sicore_pkg::OP_SPECIAL: begin
            unique case (funct) inside
               sicore_pkg::FN_SLL: begin
                  do_wr  = 1'b1;
                  wr_val = op_b << sa;
               end
               sicore_pkg::FN_SRL: begin
                  do_wr  = 1'b1;
                  wr_val = op_b >> sa;
               end
               sicore_pkg::FN_SRA: begin
                  do_wr  = 1'b1;
                  wr_val = $unsigned($signed(op_b) >>> sa);
               end
               sicore_pkg::FN_SLLV: begin
                  do_wr  = 1'b1;
                  wr_val = op_b << op_a[4:0];
               end
               sicore_pkg::FN_SRLV: begin
                  do_wr  = 1'b1;
                  wr_val = op_b >> op_a[4:0];
               end
               sicore_pkg::FN_SRAV: begin
                  do_wr  = 1'b1;
                  wr_val = $unsigned($signed(op_b) >>> op_a[4:0]);
               end
               sicore_pkg::FN_JR: begin
                  taken  = 1'b1;
                  target = op_a[sicore_pkg::PC_W-1:0];
               end
               sicore_pkg::FN_JALR: begin
                  do_wr  = 1'b1;
                  wr_val = link_val;
                  taken  = 1'b1;
                  target = op_a[sicore_pkg::PC_W-1:0];
               end
               sicore_pkg::FN_BREAK: begin
                  brk = 1'b1;
               end
               sicore_pkg::FN_ADD, sicore_pkg::FN_ADDU: begin
                  do_wr  = 1'b1;
                  wr_val = sum_ab;
               end
               sicore_pkg::FN_SUB, sicore_pkg::FN_SUBU: begin
                  do_wr  = 1'b1;
                  wr_val = diff_ab;
               end
               sicore_pkg::FN_AND: begin
                  do_wr  = 1'b1;
                  wr_val = op_a & op_b;
               end
               sicore_pkg::FN_OR: begin
                  do_wr  = 1'b1;
                  wr_val = op_a | op_b;
               end
               sicore_pkg::FN_XOR: begin
                  do_wr  = 1'b1;
                  wr_val = op_a ^ op_b;
               end
               sicore_pkg::FN_NOR: begin
                  do_wr  = 1'b1;
                  wr_val = ~(op_a | op_b);
               end
               sicore_pkg::FN_SLT: begin
                  do_wr  = 1'b1;
                  wr_val = {31'h0, ($signed(op_a) < $signed(op_b))};
               end
               sicore_pkg::FN_SLTU: begin
                  do_wr  = 1'b1;
                  wr_val = {31'h0, (op_a < op_b)};
               end
               default: begin
                  unsup = 1'b1;
               end
            endcase
         end
         sicore_pkg::OP_REGIMM: begin
            target = rel_target;
            unique case (rt_idx) inside
               sicore_pkg::RI_BLTZ: begin
                  taken = a_neg;
               end
               sicore_pkg::RI_BGEZ: begin
                  taken = !a_neg;
               end
               sicore_pkg::RI_BLTZAL: begin
                  taken  = a_neg;
                  do_wr  = 1'b1;
                  wr_idx = sicore_pkg::REG_LINK;
                  wr_val = link_val;
               end
               sicore_pkg::RI_BGEZAL: begin
                  taken  = !a_neg;
                  do_wr  = 1'b1;
                  wr_idx = sicore_pkg::REG_LINK;
                  wr_val = link_val;
               end
               default: begin
                  unsup = 1'b1;
               end
            endcase
         end
         sicore_pkg::OP_J: begin
            taken  = 1'b1;
            target = jmp_target;
         end
         sicore_pkg::OP_JAL: begin
            taken  = 1'b1;
            target = jmp_target;
            do_wr  = 1'b1;
            wr_idx = sicore_pkg::REG_LINK;
            wr_val = link_val;
         end
         sicore_pkg::OP_BEQ: begin
            taken  = (op_a == op_b);
            target = rel_target;
         end
         sicore_pkg::OP_BNE: begin
            taken  = (op_a != op_b);
            target = rel_target;
         end
         sicore_pkg::OP_BLEZ: begin
            taken  = a_zero || a_neg;
            target = rel_target;
         end
         sicore_pkg::OP_BGTZ: begin
            taken  = !a_zero && !a_neg;
            target = rel_target;
         end
         sicore_pkg::OP_ADDI, sicore_pkg::OP_ADDIU: begin
            do_wr  = 1'b1;
            wr_idx = rt_idx;
            wr_val = sum_ai;
         end
         sicore_pkg::OP_SLTI: begin
            do_wr  = 1'b1;
            wr_idx = rt_idx;
            wr_val = {31'h0, ($signed(op_a) < $signed(imm_s))};
         end
         sicore_pkg::OP_SLTIU: begin
            do_wr  = 1'b1;
            wr_idx = rt_idx;
            wr_val = {31'h0, (op_a < imm_s)};
         end
         sicore_pkg::OP_ANDI: begin
            do_wr  = 1'b1;
            wr_idx = rt_idx;
            wr_val = op_a & imm_z;
         end
         sicore_pkg::OP_ORI: begin
            do_wr  = 1'b1;
            wr_idx = rt_idx;
            wr_val = op_a | imm_z;
         end
         sicore_pkg::OP_XORI: begin
            do_wr  = 1'b1;
            wr_idx = rt_idx;
            wr_val = op_a ^ imm_z;
         end
         sicore_pkg::OP_LUI: begin
            do_wr  = 1'b1;
            wr_idx = rt_idx;
            wr_val = {instr[15:0], 16'h0000};
         end
         sicore_pkg::OP_LB: begin
            do_wr   = 1'b1;
            wr_idx  = rt_idx;
            ld_kind = sicore_pkg::LD_BYTE;
         end
         sicore_pkg::OP_LH: begin
            do_wr   = 1'b1;
            wr_idx  = rt_idx;
            ld_kind = sicore_pkg::LD_HALF;
         end
         sicore_pkg::OP_LW, sicore_pkg::OP_LWU: begin
            do_wr   = 1'b1;
            wr_idx  = rt_idx;
            ld_kind = sicore_pkg::LD_WORD;
         end
         sicore_pkg::OP_LBU: begin
            do_wr   = 1'b1;
            wr_idx  = rt_idx;
            ld_kind = sicore_pkg::LD_BYTE_U;
         end
         sicore_pkg::OP_LHU: begin
            do_wr   = 1'b1;
            wr_idx  = rt_idx;
            ld_kind = sicore_pkg::LD_HALF_U;
         end
         sicore_pkg::OP_SB: begin
            st_en   = 1'b1;
            st_size = sicore_pkg::SIZE_BYTE;
         end
         sicore_pkg::OP_SH: begin
            st_en   = 1'b1;
            st_size = sicore_pkg::SIZE_HALF;
         end
         sicore_pkg::OP_SW: begin
            st_en   = 1'b1;
            st_size = sicore_pkg::SIZE_WORD;
         end
         default: begin
            unsup = 1'b1;
         end
      endcase
   end

   // register zero never takes a write
   assign wr_ok = do_wr && (wr_idx != '0);

   assign res.reg_we    = wr_ok;
   assign res.reg_index = wr_ok ? wr_idx : '0;
   assign res.reg_value = wr_ok ? wr_val : 32'h0000_0000;
   assign res.load_kind = wr_ok ? ld_kind : sicore_pkg::LD_NONE;
   assign res.mem_we    = st_en;
   assign res.mem_size  = st_size;
   assign res.ea        = sum_ai[sicore_pkg::DMEM_AW-1:0];
   assign res.brk       = brk;
   assign res.unsup     = unsup;
   assign res.taken     = taken;
   assign res.target    = target;

endmodule
`default_nettype wire

// ===== verif/scalar_integer_core_step_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_integer_core_step_top_test
// Self-checking bench for the scalar integer core. A shadow core keeps its own
// register file, data memory and pc triple, predicts every result transfer,
// and a checker compares each one field by field. Directed cases hit value
// extremes, address wrap, branch target truncation, BREAK and unsupported
// opcodes; a random instruction stream then runs under several idle mixes.
// ----------------------------------------------------------------------------
module scalar_integer_core_step_top_test;
   import sicore_pkg::*;

   // opcodes that the core leaves out, used to build unsupported words
   localparam logic [5:0] OP_COP0  = 6'h10;
   localparam logic [5:0] OP_COP1  = 6'h11;
   localparam logic [5:0] OP_COP2  = 6'h12;
   localparam logic [5:0] OP_COP3  = 6'h13;
   localparam logic [5:0] OP_LWC2  = 6'h32;
   localparam logic [5:0] OP_SWC2  = 6'h3A;
   localparam logic [5:0] FN_UNDEF = 6'h3F;

   // cycles without any transfer before the run is declared hung
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int PRINT_LIMIT    = 40;

   typedef struct packed {
      logic [11:0] next_fetch_pc;
      logic        reg_we;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_we;
      logic [11:0] mem_addr;
      logic [1:0]  mem_size;
      logic [31:0] mem_data;
      logic        break_hit;
      logic        unsupported;
   } core_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_instr = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_next_fetch_pc;
   logic        rsp_reg_we;
   logic [4:0]  rsp_reg_index;
   logic [31:0] rsp_reg_value;
   logic        rsp_mem_we;
   logic [11:0] rsp_mem_addr;
   logic [1:0]  rsp_mem_size;
   logic [31:0] rsp_mem_data;
   logic        rsp_break_hit;
   logic        rsp_unsupported;

   // shadow core state
   logic [31:0] gpr_shadow [0:31];
   logic [7:0]  dmem_shadow [0:DMEM_BYTES-1];
   logic [11:0] pc_now;
   logic [11:0] pc_next;
   logic [11:0] pc_next2;

   core_rsp_t   expected_rsp_q [$];
   int          mismatch_count = 0;
   int          rsp_count = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   scalar_integer_core_step_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_instr         (req_instr),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_fetch_pc (rsp_next_fetch_pc),
      .rsp_reg_we        (rsp_reg_we),
      .rsp_reg_index     (rsp_reg_index),
      .rsp_reg_value     (rsp_reg_value),
      .rsp_mem_we        (rsp_mem_we),
      .rsp_mem_addr      (rsp_mem_addr),
      .rsp_mem_size      (rsp_mem_size),
      .rsp_mem_data      (rsp_mem_data),
      .rsp_break_hit     (rsp_break_hit),
      .rsp_unsupported   (rsp_unsupported)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // shadow core
   // ---------------------------------------------------------------------

   task automatic reset_shadow();
      foreach (gpr_shadow[i]) gpr_shadow[i] = 32'd0;
      foreach (dmem_shadow[i]) dmem_shadow[i] = 8'd0;
      pc_now   = 12'd0;
      pc_next  = 12'd4;
      pc_next2 = 12'd8;
   endtask

   // big-endian read, wrapping byte by byte
   function automatic logic [31:0] dmem_read(logic [11:0] addr, int n);
      logic [31:0] v;
      logic [11:0] idx;
      v = 32'd0;
      for (int k = 0; k < n; k++) begin
         idx = addr + 12'(k);
         v = {v[23:0], dmem_shadow[idx]};
      end
      return v;
   endfunction

   task automatic dmem_write(input logic [11:0] addr, input int n, input logic [31:0] v);
      logic [11:0] idx;
      for (int k = 0; k < n; k++) begin
         idx = addr + 12'(k);
         dmem_shadow[idx] = 8'(v >> (8 * (n - 1 - k)));
      end
   endtask

   // execute one instruction on the shadow core and form its result
   task automatic predict_step(input logic [31:0] instr, output core_rsp_t r);
      logic [5:0]  prim;
      logic [5:0]  funct;
      logic [4:0]  rs, rt, rd, sa, widx;
      logic [31:0] simm, zimm, a, b, rel, wval, loaded;
      logic [11:0] link, ea, nn, target;
      logic        do_wr, taken;
      prim   = instr[31:26];
      funct  = instr[5:0];
      rs     = instr[25:21];
      rt     = instr[20:16];
      rd     = instr[15:11];
      sa     = instr[10:6];
      zimm   = {16'd0, instr[15:0]};
      simm   = {{16{instr[15]}}, instr[15:0]};
      a      = (rs == 5'd0) ? 32'd0 : gpr_shadow[rs];
      b      = (rt == 5'd0) ? 32'd0 : gpr_shadow[rt];
      link   = {pc_next2[11:2], 2'b00};
      rel    = {20'd0, pc_next} + (simm << 2);
      ea     = a[11:0] + simm[11:0];
      r      = '0;
      do_wr  = 1'b0;
      widx   = rt;
      wval   = 32'd0;
      taken  = 1'b0;
      target = rel[11:0];
      case (prim)
         OP_SPECIAL: begin
            widx  = rd;
            do_wr = 1'b1;
            case (funct)
               FN_SLL:  wval = b << sa;
               FN_SRL:  wval = b >> sa;
               FN_SRA:  wval = $signed(b) >>> sa;
               FN_SLLV: wval = b << a[4:0];
               FN_SRLV: wval = b >> a[4:0];
               FN_SRAV: wval = $signed(b) >>> a[4:0];
               FN_JR: begin
                  do_wr  = 1'b0;
                  taken  = 1'b1;
                  target = a[11:0];
               end
               FN_JALR: begin
                  wval   = {20'd0, link};
                  taken  = 1'b1;
                  target = a[11:0];
               end
               FN_BREAK: begin
                  do_wr       = 1'b0;
                  r.break_hit = 1'b1;
               end
               FN_ADD, FN_ADDU: wval = a + b;
               FN_SUB, FN_SUBU: wval = a - b;
               FN_AND:  wval = a & b;
               FN_OR:   wval = a | b;
               FN_XOR:  wval = a ^ b;
               FN_NOR:  wval = ~(a | b);
               FN_SLT:  wval = {31'd0, $signed(a) < $signed(b)};
               FN_SLTU: wval = {31'd0, a < b};
               default: begin
                  do_wr         = 1'b0;
                  r.unsupported = 1'b1;
               end
            endcase
         end
         OP_REGIMM: begin
            widx = REG_LINK;
            wval = {20'd0, link};
            case (rt)
               RI_BLTZ:   taken = a[31];
               RI_BGEZ:   taken = !a[31];
               RI_BLTZAL: begin
                  taken = a[31];
                  do_wr = 1'b1;
               end
               RI_BGEZAL: begin
                  taken = !a[31];
                  do_wr = 1'b1;
               end
               default:   r.unsupported = 1'b1;
            endcase
         end
         OP_J: begin
            taken  = 1'b1;
            target = {instr[9:0], 2'b00};
         end
         OP_JAL: begin
            taken  = 1'b1;
            target = {instr[9:0], 2'b00};
            do_wr  = 1'b1;
            widx   = REG_LINK;
            wval   = {20'd0, link};
         end
         OP_BEQ:  taken = (a == b);
         OP_BNE:  taken = (a != b);
         OP_BLEZ: taken = (a == 32'd0) || a[31];
         OP_BGTZ: taken = (a != 32'd0) && !a[31];
         OP_ADDI, OP_ADDIU: begin
            do_wr = 1'b1;
            wval  = a + simm;
         end
         OP_SLTI: begin
            do_wr = 1'b1;
            wval  = {31'd0, $signed(a) < $signed(simm)};
         end
         OP_SLTIU: begin
            do_wr = 1'b1;
            wval  = {31'd0, a < simm};
         end
         OP_ANDI: begin
            do_wr = 1'b1;
            wval  = a & zimm;
         end
         OP_ORI: begin
            do_wr = 1'b1;
            wval  = a | zimm;
         end
         OP_XORI: begin
            do_wr = 1'b1;
            wval  = a ^ zimm;
         end
         OP_LUI: begin
            do_wr = 1'b1;
            wval  = {instr[15:0], 16'd0};
         end
         OP_LB: begin
            loaded = dmem_read(ea, 1);
            do_wr  = 1'b1;
            wval   = {{24{loaded[7]}}, loaded[7:0]};
         end
         OP_LH: begin
            loaded = dmem_read(ea, 2);
            do_wr  = 1'b1;
            wval   = {{16{loaded[15]}}, loaded[15:0]};
         end
         OP_LW, OP_LWU: begin
            do_wr = 1'b1;
            wval  = dmem_read(ea, 4);
         end
         OP_LBU: begin
            do_wr = 1'b1;
            wval  = dmem_read(ea, 1);
         end
         OP_LHU: begin
            do_wr = 1'b1;
            wval  = dmem_read(ea, 2);
         end
         OP_SB, OP_SH, OP_SW: begin
            r.mem_we   = 1'b1;
            r.mem_addr = ea;
            r.mem_data = b;
            if (prim == OP_SB) begin
               r.mem_size = SIZE_BYTE;
               dmem_write(ea, 1, b);
            end else if (prim == OP_SH) begin
               r.mem_size = SIZE_HALF;
               dmem_write(ea, 2, b);
            end else begin
               r.mem_size = SIZE_WORD;
               dmem_write(ea, 4, b);
            end
         end
         default: r.unsupported = 1'b1;
      endcase

      // register zero swallows writes
      if (do_wr && widx != 5'd0) begin
         gpr_shadow[widx] = wval;
         r.reg_we         = 1'b1;
         r.reg_index      = widx;
         r.reg_value      = wval;
      end

      // advance the pc triple, taken branches land after the delay slot
      nn       = taken ? target : pc_next2;
      pc_now   = {pc_next[11:2], 2'b00};
      pc_next  = nn;
      pc_next2 = nn + 12'd4;
      r.next_fetch_pc = pc_now;
   endtask

   // ---------------------------------------------------------------------
   // instruction encoders and random picks
   // ---------------------------------------------------------------------

   function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sa);
      return {OP_SPECIAL, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] tgt);
      return {op, tgt};
   endfunction

   // mostly a few low registers so that values get reused
   function automatic logic [4:0] pick_reg();
      if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
      return 5'($urandom_range(0, 7));
   endfunction

   function automatic logic [15:0] pick_imm();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hffff;
         2:       return 16'h7fff;
         3:       return 16'h8000;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [31:0] random_instr();
      int unsigned pick;
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs, rt, rd;
      logic [15:0] imm;
      pick = $urandom_range(0, 99);
      rs   = pick_reg();
      rt   = pick_reg();
      rd   = pick_reg();
      imm  = pick_imm();
      op   = OP_COP0;
      fn   = FN_SLL;
      if (pick < 6) begin
         return $urandom();
      end else if (pick < 10) begin
         // left-out coprocessor opcodes and undefined function codes
         case ($urandom_range(0, 7))
            0: op = OP_COP0;
            1: op = OP_COP1;
            2: op = OP_COP2;
            3: op = OP_COP3;
            4: op = OP_LWC2;
            5: op = OP_SWC2;
            6: return enc_r(6'($urandom_range(0, 63)), rs, rt, rd, 5'($urandom_range(0, 31)));
            default: return enc_i(OP_REGIMM, rs, 5'($urandom_range(0, 31)), imm);
         endcase
         return {op, 26'($urandom())};
      end else if (pick < 35) begin
         case ($urandom_range(0, 15))
            0:  fn = FN_SLL;
            1:  fn = FN_SRL;
            2:  fn = FN_SRA;
            3:  fn = FN_SLLV;
            4:  fn = FN_SRLV;
            5:  fn = FN_SRAV;
            6:  fn = FN_ADD;
            7:  fn = FN_ADDU;
            8:  fn = FN_SUB;
            9:  fn = FN_SUBU;
            10: fn = FN_AND;
            11: fn = FN_OR;
            12: fn = FN_XOR;
            13: fn = FN_NOR;
            14: fn = FN_SLT;
            default: fn = FN_SLTU;
         endcase
         return enc_r(fn, rs, rt, rd, 5'($urandom_range(0, 31)));
      end else if (pick < 55) begin
         case ($urandom_range(0, 7))
            0: op = OP_ADDI;
            1: op = OP_ADDIU;
            2: op = OP_SLTI;
            3: op = OP_SLTIU;
            4: op = OP_ANDI;
            5: op = OP_ORI;
            6: op = OP_XORI;
            default: op = OP_LUI;
         endcase
         return enc_i(op, rs, rt, imm);
      end else if (pick < 86) begin
         case ($urandom_range(0, 8))
            0: op = OP_LB;
            1: op = OP_LH;
            2: op = OP_LW;
            3: op = OP_LBU;
            4: op = OP_LHU;
            5: op = OP_LWU;
            6: op = OP_SB;
            7: op = OP_SH;
            default: op = OP_SW;
         endcase
         // small offsets around a base so that loads see earlier stores
         case ($urandom_range(0, 3))
            0: imm = 16'($urandom_range(0, 63));
            1: imm = 16'd0 - 16'($urandom_range(1, 64));
            2: begin
               rs  = 5'd0;
               imm = 16'($urandom_range(0, 63));
            end
            default: ;
         endcase
         return enc_i(op, rs, rt, imm);
      end else if (pick < 98) begin
         case ($urandom_range(0, 11))
            0:  return enc_j(OP_J, 26'($urandom()));
            1:  return enc_j(OP_JAL, 26'($urandom()));
            2:  return enc_r(FN_JR, rs, 5'd0, 5'd0, 5'd0);
            3:  return enc_r(FN_JALR, rs, 5'd0, rd, 5'd0);
            4:  return enc_i(OP_BEQ, rs, rt, imm);
            5:  return enc_i(OP_BNE, rs, rt, imm);
            6:  return enc_i(OP_BLEZ, rs, rt, imm);
            7:  return enc_i(OP_BGTZ, rs, rt, imm);
            8:  return enc_i(OP_REGIMM, rs, RI_BLTZ, imm);
            9:  return enc_i(OP_REGIMM, rs, RI_BGEZ, imm);
            10: return enc_i(OP_REGIMM, rs, RI_BLTZAL, imm);
            default: return enc_i(OP_REGIMM, rs, RI_BGEZAL, imm);
         endcase
      end
      return {OP_SPECIAL, 20'($urandom()), FN_BREAK};
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // one instruction transfer, with a random idle gap in front
   task automatic send_instr(input logic [31:0] instr);
      core_rsp_t want;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instr <= instr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_step(instr, want);
      expected_rsp_q.push_back(want);
   endtask

   // hold off the sender until every result is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) $display("error: result transfer %0d: %s", rsp_count, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_rsp
      core_rsp_t want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_count++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_rsp_q.pop_front();
            compare_field("next_fetch_pc", rsp_next_fetch_pc, want.next_fetch_pc);
            compare_field("reg_we", rsp_reg_we, want.reg_we);
            compare_field("reg_index", rsp_reg_index, want.reg_index);
            compare_field("reg_value", rsp_reg_value, want.reg_value);
            compare_field("mem_we", rsp_mem_we, want.mem_we);
            compare_field("mem_addr", rsp_mem_addr, want.mem_addr);
            compare_field("mem_size", rsp_mem_size, want.mem_size);
            compare_field("mem_data", rsp_mem_data, want.mem_data);
            compare_field("break_hit", rsp_break_hit, want.break_hit);
            compare_field("unsupported", rsp_unsupported, want.unsupported);
         end
      end
   end

   // hang detection: no transfer on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // value extremes, wrapping add and sub, writes to register zero
   task automatic test_extremes_and_zero_reg();
      send_instr(enc_i(OP_LUI, 5'd0, 5'd1, 16'hffff));
      send_instr(enc_i(OP_ORI, 5'd1, 5'd1, 16'hffff));
      send_instr(enc_i(OP_LUI, 5'd0, 5'd2, 16'h8000));
      send_instr(enc_i(OP_ADDIU, 5'd2, 5'd3, 16'hffff));
      send_instr(enc_r(FN_ADD, 5'd3, 5'd3, 5'd4, 5'd0));
      send_instr(enc_r(FN_SUB, 5'd2, 5'd3, 5'd0, 5'd0));
      send_instr(enc_r(FN_SLT, 5'd2, 5'd3, 5'd5, 5'd0));
      send_instr(enc_i(OP_SLTIU, 5'd3, 5'd6, 16'hffff));
   endtask

   // largest shift amounts, fixed and from a register
   task automatic test_shift_extremes();
      send_instr(enc_r(FN_SRA, 5'd0, 5'd2, 5'd7, 5'd31));
      send_instr(enc_r(FN_SRLV, 5'd1, 5'd2, 5'd8, 5'd0));
      send_instr(enc_r(FN_SLLV, 5'd1, 5'd1, 5'd9, 5'd0));
   endtask

   // accesses at the top of data memory, multi-byte ones running past it
   task automatic test_address_wrap();
      send_instr(enc_i(OP_SW, 5'd0, 5'd4, 16'hfffe));
      send_instr(enc_i(OP_LW, 5'd0, 5'd10, 16'hfffe));
      send_instr(enc_i(OP_LH, 5'd0, 5'd11, 16'h0fff));
      send_instr(enc_i(OP_SH, 5'd1, 5'd2, 16'h0000));
      send_instr(enc_i(OP_LB, 5'd0, 5'd12, 16'h0fff));
   endtask

   // jumps and branches with targets beyond 12 bits, links, delay slots
   task automatic test_control_flow();
      send_instr(enc_r(FN_JR, 5'd1, 5'd0, 5'd0, 5'd0));
      send_instr(32'd0);
      send_instr(enc_r(FN_JALR, 5'd2, 5'd0, 5'd13, 5'd0));
      send_instr(enc_i(OP_REGIMM, 5'd2, RI_BLTZAL, 16'h8000));
      send_instr(enc_j(OP_JAL, 26'h3ffffff));
      send_instr(enc_i(OP_REGIMM, 5'd0, RI_BGEZAL, 16'h7fff));
   endtask

   task automatic test_break_and_unsupported();
      send_instr({OP_SPECIAL, 20'hfffff, FN_BREAK});
      send_instr({OP_COP0, 26'd0});
      send_instr({OP_LWC2, 26'h3ffffff});
      send_instr(enc_r(FN_UNDEF, 5'd31, 5'd31, 5'd31, 5'd31));
   endtask

   // random stream under each idle mix, draining between mixes
   task automatic test_random_stream(input int per_phase);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         for (int n = 0; n < per_phase; n++) send_instr(random_instr());
         wait_for_drain();
      end
   endtask

   initial begin
      reset_shadow();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_extremes_and_zero_reg();
      test_shift_extremes();
      test_address_wrap();
      test_control_flow();
      test_break_and_unsupported();
      wait_for_drain();
      test_random_stream(306);

      // let any stray result show up before the verdict
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/sicore_pkg.sv
src/sicore_exec.sv
src/scalar_integer_core_step_top.sv
verif/scalar_integer_core_step_top_test.sv
